// ===== sv/zsrle_pkg.sv =====
package zsrle_pkg;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] MARK_ZERO  = 8'h23;
  localparam logic [7:0] MARK_SPACE = 8'h24;
  localparam logic [7:0] CHUNK_MAX  = 8'd255;
  localparam logic [7:0] SHORT_MAX  = 8'd2;
  localparam logic [7:0] NEWLINE    = 8'd10;

  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_ZERO  = 2'd1;
  localparam logic [1:0] KIND_SPACE = 2'd2;

  localparam int CMD_DEPTH = 2;

  typedef struct packed {
    logic [1:0]      len;
    logic [2:0][7:0] data;
  } cmd_t;

endpackage

// ===== sv/zsrle_front.sv =====
module zsrle_front import zsrle_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] in_byte,
  input  logic       line_end,
  output logic       cmd_valid,
  output cmd_t       cmd
);

  logic [1:0] run_kind;
  logic [7:0] run_count;
  logic       run_already_chunked;
  logic [1:0] run_kind_next;
  logic [7:0] run_count_next;
  logic       run_already_chunked_next;

  logic [1:0] kind_in;
  logic       run_open;
  logic [7:0] run_char;
  logic [7:0] run_mark;
  logic [1:0] fn;
  logic [7:0] fb0;
  logic [7:0] fb1;

  always_comb begin
    if (in_byte == CHAR_ZERO) begin
      kind_in = KIND_ZERO;
    end else if (in_byte == CHAR_SPACE) begin
      kind_in = KIND_SPACE;
    end else begin
      kind_in = KIND_NONE;
    end
    run_open = (run_kind == KIND_ZERO) || (run_kind == KIND_SPACE);
    run_char = (run_kind == KIND_ZERO) ? CHAR_ZERO : CHAR_SPACE;
    run_mark = (run_kind == KIND_ZERO) ? MARK_ZERO : MARK_SPACE;
    fn  = 2'd0;
    fb0 = run_char;
    fb1 = run_char;
    if (run_open && run_count != 8'd0) begin
      if (!run_already_chunked && run_count <= SHORT_MAX) begin
        fn = run_count[1:0];
      end else begin
        fb0 = run_mark;
        fb1 = run_count;
        fn  = 2'd2;
      end
    end
  end

  always_comb begin
    cmd.data = '0;
    cmd.len  = 2'd0;
    run_kind_next            = KIND_NONE;
    run_count_next           = 8'd0;
    run_already_chunked_next = 1'b0;
    if (line_end) begin
      cmd.data[0]  = fb0;
      cmd.data[1]  = fb1;
      cmd.data[fn] = NEWLINE;
      cmd.len      = fn + 2'd1;
    end else if (kind_in != KIND_NONE && kind_in == run_kind) begin
      run_kind_next = run_kind;
      if (run_count == CHUNK_MAX - 8'd1) begin
        cmd.data[0] = run_mark;
        cmd.data[1] = CHUNK_MAX;
        cmd.len     = 2'd2;
        run_already_chunked_next = 1'b1;
      end else begin
        run_count_next           = run_count + 8'd1;
        run_already_chunked_next = run_already_chunked;
      end
    end else begin
      cmd.data[0] = fb0;
      cmd.data[1] = fb1;
      if (kind_in != KIND_NONE) begin
        cmd.len        = fn;
        run_kind_next  = kind_in;
        run_count_next = 8'd1;
      end else begin
        cmd.data[fn] = in_byte;
        cmd.len      = fn + 2'd1;
      end
    end
    cmd_valid = accept && (cmd.len != 2'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_kind            <= KIND_NONE;
      run_count           <= 8'd0;
      run_already_chunked <= 1'b0;
    end else if (accept) begin
      run_kind            <= run_kind_next;
      run_count           <= run_count_next;
      run_already_chunked <= run_already_chunked_next;
    end
  end

endmodule

// ===== sv/zsrle_fifo.sv =====
module zsrle_fifo import zsrle_pkg::*; #(
  parameter int Depth = CMD_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  cmd_t wr_data,
  input  logic rd_en,
  output cmd_t rd_data,
  output logic full,
  output logic empty
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  cmd_t            mem [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign full    = (count == CntFull);
  assign empty   = (count == '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PtrLast) ? '0 : wr_ptr + PtrW'(1);
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PtrLast) ? '0 : rd_ptr + PtrW'(1);
      end
      if (wr_en && !rd_en) begin
        count <= count + CntW'(1);
      end else if (rd_en && !wr_en) begin
        count <= count - CntW'(1);
      end
    end
  end

endmodule

// ===== sv/zsrle_back.sv =====
module zsrle_back import zsrle_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cmd_t       head,
  input  logic       head_valid,
  input  logic       pop,
  output logic       head_done,
  output logic [7:0] out_byte,
  output logic       last
);

  logic [1:0] idx;
  logic       take;

  assign out_byte  = head.data[idx];
  assign last      = (idx == head.len - 2'd1);
  assign take      = pop && head_valid;
  assign head_done = take && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 2'd0;
    end else if (take) begin
      idx <= last ? 2'd0 : idx + 2'd1;
    end
  end

endmodule

// ===== sv/zero_space_run_length_encoder_core.sv =====
// A request accepted at a clock edge puts its results in the command queue; if the queue
// was empty, its first result is on the result ports right after that edge.
// Throughput: one request per cycle while the queue is not full and each causes at most
// one result (a request causes up to three); results leave one byte per cycle while pop
// is held. The command queue between front and back sets how far requests run ahead.
// Reset (rst, synchronous, active high) closes any open run and empties the queue.
module zero_space_run_length_encoder_core import zsrle_pkg::*; #(
  parameter int CmdDepth = CMD_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  input  logic       line_end,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       last
);

  logic accept;
  logic cmd_valid;
  cmd_t cmd;
  cmd_t head;
  logic q_empty;
  logic head_done;

  assign accept = push && !full;
  assign empty  = q_empty;

  zsrle_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .in_byte   (in_byte),
    .line_end  (line_end),
    .cmd_valid (cmd_valid),
    .cmd       (cmd)
  );

  zsrle_fifo #(
    .Depth (CmdDepth)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cmd_valid),
    .wr_data (cmd),
    .rd_en   (head_done),
    .rd_data (head),
    .full    (full),
    .empty   (q_empty)
  );

  zsrle_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (!q_empty),
    .pop        (pop),
    .head_done  (head_done),
    .out_byte   (out_byte),
    .last       (last)
  );

endmodule

// ===== tb/tb_zero_space_run_length_encoder_core.sv =====
module tb_zero_space_run_length_encoder_core;
  import zsrle_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 600000;

  typedef struct packed {
    logic [7:0] value;
    logic       is_last;
  } encoded_byte_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic [7:0] in_byte = 8'h00;
  logic       line_end = 1'b0;
  logic       pop = 1'b0;
  logic       full;
  logic       empty;
  logic [7:0] out_byte;
  logic       last;

  encoded_byte_t encoded_bytes_due[$];

  logic [1:0] run_kind;
  logic [7:0] run_count;
  logic       run_chunked;

  bit          send_idle = 1'b1;
  bit          take_idle = 1'b1;
  int          take_hold_cycles = 0;
  int unsigned cycle_count = 0;
  int unsigned requests_sent = 0;
  int unsigned lines_sent = 0;
  int unsigned bytes_checked = 0;
  int unsigned chunks_seen = 0;
  int unsigned holds_done = 0;
  int unsigned mismatches = 0;

  zero_space_run_length_encoder_core u_top (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .in_byte  (in_byte),
    .line_end (line_end),
    .empty    (empty),
    .pop      (pop),
    .out_byte (out_byte),
    .last     (last)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic void encode_request(input logic [7:0] value, input logic eol);
    logic [1:0] kind;
    logic [7:0] outs [3];
    int n;
    n = 0;
    if (value == CHAR_ZERO) kind = KIND_ZERO;
    else if (value == CHAR_SPACE) kind = KIND_SPACE;
    else kind = KIND_NONE;
    if (!eol && kind != KIND_NONE && kind == run_kind) begin
      if (run_count >= CHUNK_MAX - 8'd1) begin
        outs[n] = (kind == KIND_ZERO) ? MARK_ZERO : MARK_SPACE;
        outs[n + 1] = CHUNK_MAX;
        n = n + 2;
        run_count = 8'd0;
        run_chunked = 1'b1;
        chunks_seen++;
      end else begin
        run_count = run_count + 8'd1;
      end
    end else begin
      if ((run_kind == KIND_ZERO || run_kind == KIND_SPACE) && run_count != 8'd0) begin
        if (!run_chunked && run_count <= SHORT_MAX) begin
          for (int k = 0; k < run_count; k++) begin
            outs[n] = (run_kind == KIND_ZERO) ? CHAR_ZERO : CHAR_SPACE;
            n++;
          end
        end else begin
          outs[n] = (run_kind == KIND_ZERO) ? MARK_ZERO : MARK_SPACE;
          outs[n + 1] = run_count;
          n = n + 2;
        end
      end
      run_kind = KIND_NONE;
      run_count = 8'd0;
      run_chunked = 1'b0;
      if (eol) begin
        outs[n] = NEWLINE;
        n++;
      end else if (kind != KIND_NONE) begin
        run_kind = kind;
        run_count = 8'd1;
      end else begin
        outs[n] = value;
        n++;
      end
    end
    for (int i = 0; i < n; i++) begin
      encoded_bytes_due.push_back('{value: outs[i], is_last: (i == n - 1)});
    end
  endfunction

  task automatic check_result(input logic [7:0] got_byte, input logic got_last);
    encoded_byte_t due;
    bytes_checked++;
    if (encoded_bytes_due.size() == 0) begin
      $error("unexpected output: out_byte %0d, last %0b", got_byte, got_last);
      mismatches++;
    end else begin
      due = encoded_bytes_due.pop_front();
      if (got_byte !== due.value) begin
        $error("out_byte: expected %0d, actual %0d", due.value, got_byte);
        mismatches++;
      end
      if (got_last !== due.is_last) begin
        $error("last: expected %0b, actual %0b", due.is_last, got_last);
        mismatches++;
      end
    end
  endtask

  initial begin : take_results
    int gap;
    wait (!rst);
    forever begin
      if (take_hold_cycles > 0) begin
        pop <= 1'b0;
        repeat (take_hold_cycles) @(posedge clk);
        take_hold_cycles = 0;
        holds_done++;
      end
      gap = take_idle ? $urandom_range(0, 15) : 0;
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
      check_result(out_byte, last);
    end
  end

  task automatic send_request(input logic [7:0] value, input logic eol);
    int gap;
    gap = send_idle ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    in_byte <= value;
    line_end <= eol;
    @(posedge clk);
    while (full) @(posedge clk);
    encode_request(value, eol);
    requests_sent++;
    if (eol) lines_sent++;
  endtask

  task automatic send_run(input logic [7:0] value, input int len);
    repeat (len) send_request(value, 1'b0);
  endtask

  task automatic send_line_end();
    send_request(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic test_directed_cases();
    send_request("A", 1'b0);
    send_request(8'h00, 1'b0);
    send_request(8'hFF, 1'b0);
    send_line_end();
    send_request(CHAR_ZERO, 1'b0);
    send_request("b", 1'b0);
    send_run(CHAR_ZERO, 2);
    send_request(CHAR_ZERO, 1'b1);
    send_run(CHAR_SPACE, 1);
    send_run(CHAR_ZERO, 3);
    send_run(CHAR_SPACE, 3);
    send_request(8'hFF, 1'b1);
    send_run(CHAR_SPACE, 2);
    send_run(CHAR_ZERO, 1);
    send_request(NEWLINE, 1'b0);
    send_run(CHAR_SPACE, 2);
    send_request(CHAR_SPACE, 1'b1);
    send_line_end();
  endtask

  task automatic test_chunked_runs();
    send_run(CHAR_ZERO, 256);
    send_line_end();
  endtask

  task automatic test_backpressure();
    send_idle = 1'b0;
    take_hold_cycles = 300;
    for (int i = 0; i < 40; i++) begin
      send_request(8'h61 + i[7:0], 1'b0);
    end
    send_line_end();
    send_idle = 1'b1;
  endtask

  task automatic test_random_lines(input int n_items);
    int unsigned first;
    int segs;
    first = requests_sent;
    while (requests_sent - first < n_items) begin
      segs = $urandom_range(1, 8);
      repeat (segs) begin
        case ($urandom_range(0, 5))
          0, 1: send_run(CHAR_ZERO, $urandom_range(1, 6));
          2: send_run(CHAR_SPACE, $urandom_range(1, 6));
          3: send_request(8'($urandom_range(33, 126)), 1'b0);
          4: send_request(8'($urandom_range(0, 255)), 1'b0);
          default: send_request(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
        endcase
      end
      if ($urandom_range(0, 9) != 0) send_line_end();
    end
  endtask

  initial begin
    run_kind = KIND_NONE;
    run_count = 8'd0;
    run_chunked = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_chunked_runs();
    test_backpressure();
    send_idle = 1'b1;
    take_idle = 1'b1;
    test_random_lines(45);
    send_idle = 1'b0;
    take_idle = 1'b0;
    test_random_lines(45);
    send_idle = 1'b0;
    take_idle = 1'b1;
    test_random_lines(40);
    send_idle = 1'b1;
    take_idle = 1'b0;
    test_random_lines(40);
    send_line_end();
    push <= 1'b0;

    while (encoded_bytes_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Covered %0d requests over %0d lines, %0d output bytes checked.",
             requests_sent, lines_sent, bytes_checked);
    $display("Full 255-byte chunks: %0d, long receiver hold-offs: %0d, mismatches: %0d.",
             chunks_seen, holds_done, mismatches);
    if (mismatches == 0 && encoded_bytes_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== zero_space_run_length_encoder_core.f =====
sv/zsrle_pkg.sv
sv/zsrle_front.sv
sv/zsrle_fifo.sv
sv/zsrle_back.sv
sv/zero_space_run_length_encoder_core.sv
tb/tb_zero_space_run_length_encoder_core.sv
